// File: hw/rtl/avr_pkg.sv
// Shared constants, types and the arctangent table for the vector rotator.
// Used by every module of the rotator; depends on nothing else.
package avr_pkg;

  // Saturation range of a rotated component and length of the CORDIC chain.
  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 24;

  // Widths of the fixed fields and of the internal datapath.
  localparam int VEC_W   = 32;              // Q16.16 vector component
  localparam int ANG_W   = 33;              // angle after optional negation
  localparam int U_W     = 33;              // angle offset into non-negative range
  localparam int CORD_W  = 34;              // CORDIC x, y and z in Q2.30
  localparam int PROD_W  = VEC_W + CORD_W;  // component times sine or cosine
  localparam int SUM_W   = PROD_W + 1;      // sum of two products
  localparam int R0_W    = 20;              // remainder estimate, below 2*(2*pi)
  localparam int R_W     = 21;              // signed reduced angle in Q16.16
  localparam int Q30_SHIFT  = 14;           // Q16.16 to Q2.30
  localparam int FRAC_SHIFT = 30;           // Q16.16*Q2.30 back to Q16.16

  // Angle constants in Q16.16 and the CORDIC gain in Q2.30.
  localparam longint TWO_PI_Q16  = 411775;
  localparam longint PI_Q16      = 205887;
  localparam longint HALF_PI_Q16 = 102944;
  localparam longint GAIN_Q30    = 652032874;
  localparam int     TWO_PI_W    = 19;

  // Smallest multiple of 2*pi that lifts every angle to a non-negative value.
  localparam longint ANGLE_OFFSET =
      ((longint'(1) <<< 31) + TWO_PI_Q16 - 1) / TWO_PI_Q16 * TWO_PI_Q16;

  // Truncated reciprocal of 2*pi; the quotient estimate is low by at most one.
  localparam int     RECIP_SHIFT = 40;
  localparam int     RECIP_W     = 22;
  localparam longint RECIP       = (longint'(1) <<< RECIP_SHIFT) / TWO_PI_Q16;
  localparam int     Q_W         = U_W + RECIP_W - RECIP_SHIFT;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_CW   = 2'd1,
    MODE_CCW  = 2'd2,
    MODE_BAD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_MODE = 2'd1,
    ST_BAD_AXIS = 2'd2
  } status_e;

  // Per-item information that rides along the pipeline beside the angle.
  typedef struct packed {
    logic                    pass;    // vector goes out unchanged
    axis_e                   axis;
    status_e                 status;
    logic                    flip;    // negate cosine and sine
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } side_t;

  typedef struct packed {
    logic [VEC_W-1:0] x;
    logic [VEC_W-1:0] y;
    logic [VEC_W-1:0] z;
    status_e          status;
  } result_t;

  // Truncated arctangent of 2^-k in Q2.30.
  function automatic logic [CORD_W-1:0] atan_q30(input int unsigned k);
    case (k)
      0:       atan_q30 = 34'd843314856;
      1:       atan_q30 = 34'd497837829;
      2:       atan_q30 = 34'd263043836;
      3:       atan_q30 = 34'd133525158;
      4:       atan_q30 = 34'd67021686;
      5:       atan_q30 = 34'd33543515;
      6:       atan_q30 = 34'd16775850;
      7:       atan_q30 = 34'd8388437;
      8:       atan_q30 = 34'd4194282;
      9:       atan_q30 = 34'd2097149;
      10:      atan_q30 = 34'd1048575;
      11:      atan_q30 = 34'd524287;
      12:      atan_q30 = 34'd262143;
      13:      atan_q30 = 34'd131071;
      14:      atan_q30 = 34'd65535;
      15:      atan_q30 = 34'd32767;
      16:      atan_q30 = 34'd16383;
      17:      atan_q30 = 34'd8191;
      18:      atan_q30 = 34'd4095;
      19:      atan_q30 = 34'd2047;
      20:      atan_q30 = 34'd1023;
      21:      atan_q30 = 34'd511;
      22:      atan_q30 = 34'd255;
      23:      atan_q30 = 34'd127;
      24:      atan_q30 = 34'd63;
      25:      atan_q30 = 34'd31;
      26:      atan_q30 = 34'd15;
      27:      atan_q30 = 34'd7;
      28:      atan_q30 = 34'd3;
      29:      atan_q30 = 34'd1;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

// File: hw/rtl/avr_angle_reduce.sv
// Four-stage angle reduction: mode decode, modulo 2*pi by reciprocal, fold to
// [-pi/2, pi/2] and conversion to Q2.30. Depends on avr_pkg.
module avr_angle_reduce (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [1:0]                         mode_i,
  input  logic [1:0]                         axis_i,
  input  logic signed [avr_pkg::VEC_W-1:0]   angle_i,
  input  logic signed [avr_pkg::VEC_W-1:0]   x_i,
  input  logic signed [avr_pkg::VEC_W-1:0]   y_i,
  input  logic signed [avr_pkg::VEC_W-1:0]   z_i,
  output logic                               valid_o,
  output logic signed [avr_pkg::CORD_W-1:0]  z_o,
  output avr_pkg::side_t                     side_o
);

  localparam int AW  = avr_pkg::ANG_W;
  localparam int UW  = avr_pkg::U_W;
  localparam int RW  = avr_pkg::RECIP_W;
  localparam int QW  = avr_pkg::Q_W;
  localparam int TW  = avr_pkg::TWO_PI_W;
  localparam int R0W = avr_pkg::R0_W;
  localparam int RSW = avr_pkg::R_W;
  localparam int CW  = avr_pkg::CORD_W;

  localparam logic signed [AW:0]  OFFSET_V  = (AW+1)'(avr_pkg::ANGLE_OFFSET);
  localparam logic [RW-1:0]       RECIP_V   = RW'(avr_pkg::RECIP);
  localparam logic [TW-1:0]       TWO_PI_U  = TW'(avr_pkg::TWO_PI_Q16);
  localparam logic signed [RSW-1:0] TWO_PI_S  = RSW'(avr_pkg::TWO_PI_Q16);
  localparam logic signed [RSW-1:0] PI_S      = RSW'(avr_pkg::PI_Q16);
  localparam logic signed [RSW-1:0] HALF_PI_S = RSW'(avr_pkg::HALF_PI_Q16);

  logic                  v1_q, v2_q, v3_q, v4_q;
  logic [UW-1:0]         u1_d, u1_q, u2_q;
  logic [QW-1:0]         q2_d, q2_q;
  logic [R0W-1:0]        r3_d, r3_q;
  logic signed [CW-1:0]  z4_d, z4_q;
  avr_pkg::side_t        sd1_d, sd1_q, sd2_q, sd3_q, sd4_d, sd4_q;

  // Stage 1: decode mode and axis, negate for clockwise, lift to >= 0.
  always_comb begin
    avr_pkg::mode_e         mode;
    logic signed [AW-1:0]   a_ext;
    logic signed [AW-1:0]   a_dir;
    logic signed [AW:0]     a_sum;
    mode         = avr_pkg::mode_e'(mode_i);
    sd1_d.axis   = avr_pkg::axis_e'(axis_i);
    sd1_d.flip   = 1'b0;
    sd1_d.x      = x_i;
    sd1_d.y      = y_i;
    sd1_d.z      = z_i;
    unique case (mode) inside
      avr_pkg::MODE_NONE: begin
        sd1_d.pass   = 1'b1;
        sd1_d.status = avr_pkg::ST_OK;
      end
      avr_pkg::MODE_BAD: begin
        sd1_d.pass   = 1'b1;
        sd1_d.status = avr_pkg::ST_BAD_MODE;
      end
      avr_pkg::MODE_CW, avr_pkg::MODE_CCW: begin
        if (sd1_d.axis == avr_pkg::AXIS_BAD) begin
          sd1_d.pass   = 1'b1;
          sd1_d.status = avr_pkg::ST_BAD_AXIS;
        end else begin
          sd1_d.pass   = 1'b0;
          sd1_d.status = avr_pkg::ST_OK;
        end
      end
    endcase
    a_ext = {angle_i[avr_pkg::VEC_W-1], angle_i};
    a_dir = (mode == avr_pkg::MODE_CW) ? -a_ext : a_ext;
    a_sum = {a_dir[AW-1], a_dir} + OFFSET_V;
    u1_d  = a_sum[UW-1:0];
  end

  // Stage 2: quotient estimate from the truncated reciprocal.
  always_comb begin
    logic [UW+RW-1:0] prod;
    prod = u1_q * RECIP_V;
    q2_d = prod[UW+RW-1 -: QW];
  end

  // Stage 3: remainder estimate, known to lie below twice 2*pi.
  always_comb begin
    logic [QW+TW-1:0] qc;
    logic [QW+TW-1:0] diff;
    qc   = q2_q * TWO_PI_U;
    diff = {{(QW+TW-UW){1'b0}}, u2_q} - qc;
    r3_d = diff[R0W-1:0];
  end

  // Stage 4: final correction, move into (-pi, pi], fold into [-pi/2, pi/2].
  always_comb begin
    logic [R0W-1:0]        r_mod;
    logic signed [RSW-1:0] r_pi;
    logic signed [RSW-1:0] r_fold;
    logic                  flip;
    r_mod = (r3_q >= R0W'(TWO_PI_U)) ? r3_q - R0W'(TWO_PI_U) : r3_q;
    r_pi  = $signed({1'b0, r_mod});
    if (r_pi > PI_S) begin
      r_pi = r_pi - TWO_PI_S;
    end
    flip   = 1'b0;
    r_fold = r_pi;
    if (r_pi > HALF_PI_S) begin
      r_fold = r_pi - PI_S;
      flip   = 1'b1;
    end else if (r_pi < -HALF_PI_S) begin
      r_fold = r_pi + PI_S;
      flip   = 1'b1;
    end
    z4_d       = {{(CW-RSW){r_fold[RSW-1]}}, r_fold} <<< avr_pkg::Q30_SHIFT;
    sd4_d      = sd3_q;
    sd4_d.flip = flip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q        <= u1_d;
      sd1_q       <= sd1_d;
      u2_q        <= u1_q;
      q2_q        <= q2_d;
      sd2_q       <= sd1_q;
      r3_q        <= r3_d;
      sd3_q       <= sd2_q;
      z4_q        <= z4_d;
      sd4_q       <= sd4_d;
    end
  end

  assign valid_o = v4_q;
  assign z_o     = z4_q;
  assign side_o  = sd4_q;

endmodule

// File: hw/rtl/avr_cordic.sv
// Unrolled CORDIC in rotation mode, one micro-rotation per register stage.
// Produces cosine and sine in Q2.30. Depends on avr_pkg.
module avr_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [avr_pkg::CORD_W-1:0]  z_i,
  input  avr_pkg::side_t                     side_i,
  output logic                               valid_o,
  output logic signed [avr_pkg::CORD_W-1:0]  cos_o,
  output logic signed [avr_pkg::CORD_W-1:0]  sin_o,
  output avr_pkg::side_t                     side_o
);

  localparam int STEPS = avr_pkg::CORDIC_STEPS;
  localparam int CW    = avr_pkg::CORD_W;
  localparam logic signed [CW-1:0] GAIN_V = CW'(avr_pkg::GAIN_Q30);

  logic [STEPS-1:0]     v_q;
  logic signed [CW-1:0] cx_q  [STEPS];
  logic signed [CW-1:0] cy_q  [STEPS];
  logic signed [CW-1:0] zz_q  [STEPS];
  logic signed [CW-1:0] cx_d  [STEPS];
  logic signed [CW-1:0] cy_d  [STEPS];
  logic signed [CW-1:0] zz_d  [STEPS];
  logic signed [CW-1:0] cx_in [STEPS];
  logic signed [CW-1:0] cy_in [STEPS];
  logic signed [CW-1:0] zz_in [STEPS];
  avr_pkg::side_t       sd_q  [STEPS];
  avr_pkg::side_t       sd_in [STEPS];

  always_comb begin
    cx_in[0] = GAIN_V;
    cy_in[0] = '0;
    zz_in[0] = z_i;
    sd_in[0] = side_i;
    for (int i = 1; i < STEPS; i++) begin
      cx_in[i] = cx_q[i-1];
      cy_in[i] = cy_q[i-1];
      zz_in[i] = zz_q[i-1];
      sd_in[i] = sd_q[i-1];
    end
  end

  // Each stage turns by +/- atan(2^-i); the shifts are floor divisions.
  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      if (!zz_in[i][CW-1]) begin
        cx_d[i] = cx_in[i] - (cy_in[i] >>> i);
        cy_d[i] = cy_in[i] + (cx_in[i] >>> i);
        zz_d[i] = zz_in[i] - $signed(avr_pkg::atan_q30(i));
      end else begin
        cx_d[i] = cx_in[i] + (cy_in[i] >>> i);
        cy_d[i] = cy_in[i] - (cx_in[i] >>> i);
        zz_d[i] = zz_in[i] + $signed(avr_pkg::atan_q30(i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < STEPS; i++) begin
        cx_q[i] <= cx_d[i];
        cy_q[i] <= cy_d[i];
        zz_q[i] <= zz_d[i];
        sd_q[i] <= sd_in[i];
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign cos_o   = cx_q[STEPS-1];
  assign sin_o   = cy_q[STEPS-1];
  assign side_o  = sd_q[STEPS-1];

endmodule

// File: hw/rtl/avr_rotate.sv
// Four-stage rotation back end: operand select, products, sums, then rounding
// and saturation with result assembly. Depends on avr_pkg.
module avr_rotate (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [avr_pkg::CORD_W-1:0]  cos_i,
  input  logic signed [avr_pkg::CORD_W-1:0]  sin_i,
  input  avr_pkg::side_t                     side_i,
  output logic                               valid_o,
  output avr_pkg::result_t                   result_o
);

  localparam int VW = avr_pkg::VEC_W;
  localparam int CW = avr_pkg::CORD_W;
  localparam int PW = avr_pkg::PROD_W;
  localparam int SW = avr_pkg::SUM_W;
  localparam int FS = avr_pkg::FRAC_SHIFT;

  localparam logic signed [SW-1:0] HALF_V = SW'(longint'(1) <<< (FS - 1));
  localparam logic signed [SW-1:0] SAT_HI =
      SW'((longint'(1) <<< (avr_pkg::COORD_WIDTH - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic                  v1_q, v2_q, v3_q, v4_q;
  logic signed [VW-1:0]  p1_d, q1_d, p1_q, q1_q;
  logic signed [CW-1:0]  c1_d, s1_d, c1_q, s1_q;
  logic signed [PW-1:0]  pc_q, qs_q, ps_q, qc_q;
  logic signed [SW-1:0]  ra_q, rb_q;
  avr_pkg::side_t        sd1_q, sd2_q, sd3_q;
  avr_pkg::result_t      res4_d, res4_q;

  // Round to nearest with ties away from zero, then clamp.
  function automatic logic [VW-1:0] round_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] r;
    t = v + (v[SW-1] ? HALF_V - SW'(1) : HALF_V);
    r = t >>> FS;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    round_sat = r[VW-1:0];
  endfunction

  // Stage 1: pick the pair that lies across the axis; the pair (p, q) turns
  // into (p*c - q*s, p*s + q*c).
  always_comb begin
    c1_d = side_i.flip ? -cos_i : cos_i;
    s1_d = side_i.flip ? -sin_i : sin_i;
    case (side_i.axis)
      avr_pkg::AXIS_X: begin
        p1_d = side_i.y;
        q1_d = side_i.z;
      end
      avr_pkg::AXIS_Y: begin
        p1_d = side_i.z;
        q1_d = side_i.x;
      end
      default: begin
        p1_d = side_i.x;
        q1_d = side_i.y;
      end
    endcase
  end

  // Stage 4: scale back to Q16.16 and place the turned pair.
  always_comb begin
    logic [VW-1:0] oa;
    logic [VW-1:0] ob;
    oa            = round_sat(ra_q);
    ob            = round_sat(rb_q);
    res4_d.x      = sd3_q.x;
    res4_d.y      = sd3_q.y;
    res4_d.z      = sd3_q.z;
    res4_d.status = sd3_q.status;
    if (!sd3_q.pass) begin
      case (sd3_q.axis)
        avr_pkg::AXIS_X: begin
          res4_d.y = oa;
          res4_d.z = ob;
        end
        avr_pkg::AXIS_Y: begin
          res4_d.z = oa;
          res4_d.x = ob;
        end
        default: begin
          res4_d.x = oa;
          res4_d.y = ob;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= p1_d;
      q1_q   <= q1_d;
      c1_q   <= c1_d;
      s1_q   <= s1_d;
      sd1_q  <= side_i;
      pc_q   <= PW'(p1_q * c1_q);
      qs_q   <= PW'(q1_q * s1_q);
      ps_q   <= PW'(p1_q * s1_q);
      qc_q   <= PW'(q1_q * c1_q);
      sd2_q  <= sd1_q;
      ra_q   <= {pc_q[PW-1], pc_q} - {qs_q[PW-1], qs_q};
      rb_q   <= {ps_q[PW-1], ps_q} + {qc_q[PW-1], qc_q};
      sd3_q  <= sd2_q;
      res4_q <= res4_d;
    end
  end

  assign valid_o  = v4_q;
  assign result_o = res4_q;

endmodule

// File: hw/rtl/avr_out_buf.sv
// Two-entry output queue that decouples the pipeline from the result stream.
// Depends on avr_pkg for the result type.
module avr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  avr_pkg::result_t data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output avr_pkg::result_t data_o,
  output logic             full_o
);

  localparam logic [1:0] DEPTH = 2'd2;

  avr_pkg::result_t mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign do_pop = pop_i & (cnt_q != 2'd0);

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign full_o  = cnt_q == DEPTH;

endmodule

// File: hw/rtl/axis_vector_rotator.sv
// The delay from an accepted input beat to its output beat is set by the pipeline
// depth. Throughput: one beat per cycle while the output queue can take results;
// every pipeline stage takes a new item each cycle in which the pipeline advances.
// Reset: rst_ni is asynchronous and active low; it clears all valid bits and
// the output queue, and the block accepts beats in the first cycle after it.
module axis_vector_rotator (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // angle[31:0], x_in, y_in, z_in
  input  logic [3:0]   s_axis_tuser_i,   // mode[1:0], axis[3:2]
  // Result stream.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,   // x_out[31:0], y_out, z_out
  output logic [1:0]   m_axis_tuser_o    // status[1:0]
);

  localparam int VW = avr_pkg::VEC_W;
  localparam int CW = avr_pkg::CORD_W;

  // The whole pipeline moves as one: it advances whenever the output queue
  // can take what leaves the last stage. Items keep their valid bits, so a
  // frozen pipeline neither drops nor repeats anything, and the queue lets
  // the input keep flowing for a while after the result side stalls.
  logic pipe_en;
  logic buf_full;

  logic                 red_valid;
  logic signed [CW-1:0] red_z;
  avr_pkg::side_t       red_side;

  logic                 cor_valid;
  logic signed [CW-1:0] cor_cos;
  logic signed [CW-1:0] cor_sin;
  avr_pkg::side_t       cor_side;

  logic                 rot_valid;
  avr_pkg::result_t     rot_result;

  avr_pkg::result_t     out_result;

  assign pipe_en         = ~buf_full | m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;

  // Angle reduction: the mode and axis decode also settles pass-through and
  // the status code here, so later stages only carry the decision along.
  avr_angle_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid_i),
    .mode_i  (s_axis_tuser_i[1:0]),
    .axis_i  (s_axis_tuser_i[3:2]),
    .angle_i (s_axis_tdata_i[31:0]),
    .x_i     (s_axis_tdata_i[63:32]),
    .y_i     (s_axis_tdata_i[95:64]),
    .z_i     (s_axis_tdata_i[127:96]),
    .valid_o (red_valid),
    .z_o     (red_z),
    .side_o  (red_side)
  );

  // Sine and cosine of the folded angle, one micro-rotation per stage.
  avr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (red_valid),
    .z_i     (red_z),
    .side_i  (red_side),
    .valid_o (cor_valid),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin),
    .side_o  (cor_side)
  );

  // Products, sums, rounding and saturation of the two turned components.
  avr_rotate u_rotate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (cor_valid),
    .cos_i    (cor_cos),
    .sin_i    (cor_sin),
    .side_i   (cor_side),
    .valid_o  (rot_valid),
    .result_o (rot_result)
  );

  // A result enters the queue exactly when the pipeline steps with a valid
  // item in its last stage.
  avr_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rot_valid & pipe_en),
    .data_i  (rot_result),
    .pop_i   (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .data_o  (out_result),
    .full_o  (buf_full)
  );

  assign m_axis_tdata_o = {out_result.z[VW-1:0], out_result.y[VW-1:0],
                           out_result.x[VW-1:0]};
  assign m_axis_tuser_o = out_result.status;

  // Input back-pressure only ever comes from a stalled, full result side.
  a_ready_only_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i)
  ) else $error("input stalled while the result side was free");

  // A finished result that cannot leave the pipeline stays in place.
  a_frozen_result_kept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rot_valid && !pipe_en) |=> rot_valid
  ) else $error("result in the last pipeline stage lost during a stall");

endmodule

// File: test/tb.sv
// Self-checking testbench for axis_vector_rotator: drives beats with random bursts and
// gaps, predicts every result with its own CORDIC rotation model, and checks each result beat.
// Depends on avr_pkg for the mode, axis and status codes and the rotator's size constants.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound on the run.
  localparam int CYCLE_LIMIT  = 400000;
  // Number of random beats after the directed part.
  localparam int RANDOM_BEATS = 900;
  // Beats accepted before the receiver starts its long hold-off.
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 250;
  // Drain time after the last expected result.
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    avr_pkg::mode_e     mode;
    avr_pkg::axis_e     axis;
    logic signed [31:0] angle;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } rot_beat_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic [3:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [95:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  // Beats waiting to be offered, and the rotated vectors still owed by the block.
  rot_beat_t          pending_beats[$];
  avr_pkg::result_t   expected_results[$];

  // Truncated arctangent of 2^-k in Q2.30, the CORDIC angle steps.
  longint arctan_q30 [0:31] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1, 0, 0
  };

  int   cycles      = 0;
  int   beats_in    = 0;
  int   results_in  = 0;
  int   mismatches  = 0;
  int   rotations   = 0;
  int   passthrough = 0;
  int   error_codes = 0;
  bit   beat_taken  = 1'b0;
  int   hold_left   = 0;

  axis_vector_rotator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset is released on a falling edge.
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Divides a Q16.16 x Q2.30 product back to Q16.16, rounding half away from zero,
  // and clamps it to the signed coordinate range.
  function automatic logic [31:0] round_saturate(input longint prod);
    longint v;
    longint hi;
    longint lo;
    if (prod >= 0) v = (prod + (longint'(1) <<< 29)) >>> avr_pkg::FRAC_SHIFT;
    else v = -((-prod + (longint'(1) <<< 29)) >>> avr_pkg::FRAC_SHIFT);
    hi = (longint'(1) <<< (avr_pkg::COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return v[31:0];
  endfunction

  // Expected output beat for one input beat.
  function automatic avr_pkg::result_t rotate_vector(input rot_beat_t b);
    avr_pkg::result_t r;
    longint  ang;
    longint  rem;
    longint  zc;
    longint  cx;
    longint  cy;
    longint  dx;
    longint  dy;
    longint  px;
    longint  py;
    longint  pz;
    bit      flip;
    r.x = b.x;
    r.y = b.y;
    r.z = b.z;
    r.status = avr_pkg::ST_OK;
    // With no rotation requested the axis is not even looked at.
    if (b.mode == avr_pkg::MODE_NONE) return r;
    if (b.mode == avr_pkg::MODE_BAD) begin
      r.status = avr_pkg::ST_BAD_MODE;
      return r;
    end
    if (b.axis == avr_pkg::AXIS_BAD) begin
      r.status = avr_pkg::ST_BAD_AXIS;
      return r;
    end
    // Clockwise turns by the negated angle; negating the most negative angle needs 33 bits.
    ang = longint'(b.angle);
    if (b.mode == avr_pkg::MODE_CW) ang = -ang;
    // Reduce into (-pi, pi], then fold into [-pi/2, pi/2] and remember to negate.
    rem = ang % avr_pkg::TWO_PI_Q16;
    if (rem < 0) rem += avr_pkg::TWO_PI_Q16;
    if (rem > avr_pkg::PI_Q16) rem -= avr_pkg::TWO_PI_Q16;
    flip = 1'b0;
    if (rem > avr_pkg::HALF_PI_Q16) begin
      rem -= avr_pkg::PI_Q16;
      flip = 1'b1;
    end else if (rem < -avr_pkg::HALF_PI_Q16) begin
      rem += avr_pkg::PI_Q16;
      flip = 1'b1;
    end
    zc = rem <<< avr_pkg::Q30_SHIFT;
    cx = avr_pkg::GAIN_Q30;
    cy = 0;
    for (int i = 0; i < avr_pkg::CORDIC_STEPS; i++) begin
      dx = cy >>> (i & 31);
      dy = cx >>> (i & 31);
      if (zc >= 0) begin
        cx -= dx;
        cy += dy;
        zc -= arctan_q30[i & 31];
      end else begin
        cx += dx;
        cy -= dy;
        zc += arctan_q30[i & 31];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    px = longint'(b.x);
    py = longint'(b.y);
    pz = longint'(b.z);
    // The component along the axis stays as it came in.
    case (b.axis)
      avr_pkg::AXIS_X: begin
        r.y = round_saturate(py * cx - pz * cy);
        r.z = round_saturate(py * cy + pz * cx);
      end
      avr_pkg::AXIS_Y: begin
        r.x = round_saturate(px * cx + pz * cy);
        r.z = round_saturate(pz * cx - px * cy);
      end
      default: begin
        r.x = round_saturate(px * cx - py * cy);
        r.y = round_saturate(px * cy + py * cx);
      end
    endcase
    return r;
  endfunction

  function automatic void queue_beat(input avr_pkg::mode_e m, input avr_pkg::axis_e a,
                                     input int ang, input int x, input int y, input int z);
    rot_beat_t b;
    b.mode = m;
    b.axis = a;
    b.angle = ang;
    b.x = x;
    b.y = y;
    b.z = z;
    pending_beats.push_back(b);
  endfunction

  // Coordinates: full-range noise, values hugging the extremes, and moderate magnitudes.
  function automatic int pick_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom);
      4: v = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                  : 32'h8000_0000 + $urandom_range(0, 3);
      default: v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
    return v;
  endfunction

  // Holds the stimulus back until the driver is empty and every result has come home.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Stimulus: directed corners, a full drain, then random beats with one more drain midway.
  initial begin
    int              r;
    int              ang;
    int              unit;
    avr_pkg::mode_e  m;
    avr_pkg::axis_e  a;
    // Mode none leaves the vector alone even with a bad axis.
    queue_beat(avr_pkg::MODE_NONE, avr_pkg::AXIS_BAD, 32'h7fff_ffff,
               32'h8000_0000, 32'h7fff_ffff, -1);
    queue_beat(avr_pkg::MODE_NONE, avr_pkg::AXIS_X, 102944,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    // A bad mode is reported ahead of a bad axis.
    queue_beat(avr_pkg::MODE_BAD, avr_pkg::AXIS_Z, 51472,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    queue_beat(avr_pkg::MODE_BAD, avr_pkg::AXIS_BAD, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
    // Bad axis with either rotating mode.
    queue_beat(avr_pkg::MODE_CW, avr_pkg::AXIS_BAD, 51472,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_BAD, -51472, -1, 1, 32'h7fff_ffff);
    // Quarter turns about each axis, both directions.
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_X, 102944,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Y, 102944,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Z, 102944,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    queue_beat(avr_pkg::MODE_CW, avr_pkg::AXIS_X, 102944,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    queue_beat(avr_pkg::MODE_CW, avr_pkg::AXIS_Y, 102944,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    queue_beat(avr_pkg::MODE_CW, avr_pkg::AXIS_Z, 102944,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    // Angle extremes; clockwise with the most negative angle negates past 32 bits.
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Z, 0,
               32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Z, 32'h7fff_ffff,
               32'h0100_0000, -32'h0080_0000, 5);
    queue_beat(avr_pkg::MODE_CW, avr_pkg::AXIS_Z, 32'h8000_0000,
               32'h0100_0000, 32'h0080_0000, 5);
    // Just past the folding points at plus and minus half pi, and at and just past pi.
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Z, 102945, 32'h0001_0000, 32'h0000_8000, 0);
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Z, -102945, 32'h0001_0000, 32'h0000_8000, 0);
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Y, 205887, 32'h0001_0000, 0, 32'h0001_0000);
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Y, 205888, 32'h0001_0000, 0, 32'h0001_0000);
    queue_beat(avr_pkg::MODE_CW, avr_pkg::AXIS_X, -205887, 0, 32'h0001_0000, -32'h0001_0000);
    // An eighth turn of full-scale vectors drives one component into saturation.
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Z, 51472, 32'h7fff_ffff, 32'h7fff_ffff, 1);
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_Z, 51472, 32'h8000_0000, 32'h8000_0000, -1);
    // A full turn and a tiny negative angle.
    queue_beat(avr_pkg::MODE_CCW, avr_pkg::AXIS_X, 411775,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_beat(avr_pkg::MODE_CW, avr_pkg::AXIS_Y, -1,
               32'h1234_5678, -32'h0765_4321, 32'h0abc_def0);
    wait_drained();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // The sender stops once midway and lets the pipeline run completely dry.
      if (n == RANDOM_BEATS / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 7) m = avr_pkg::MODE_NONE;
      else if (r < 15) m = avr_pkg::MODE_BAD;
      else if (r < 57) m = avr_pkg::MODE_CW;
      else m = avr_pkg::MODE_CCW;
      a = ($urandom_range(0, 9) == 0) ? avr_pkg::AXIS_BAD
                                      : avr_pkg::axis_e'($urandom_range(0, 2));
      r = $urandom_range(0, 9);
      if (r < 5) begin
        ang = int'($urandom);
      end else if (r < 8) begin
        ang = int'($urandom_range(0, 4 * 411775)) - 2 * 411775;
      end else begin
        // Near a multiple of half pi, pi or two pi, where the reduction changes branch.
        case ($urandom_range(0, 2))
          0:       unit = int'(avr_pkg::HALF_PI_Q16);
          1:       unit = int'(avr_pkg::PI_Q16);
          default: unit = int'(avr_pkg::TWO_PI_Q16);
        endcase
        ang = unit * (int'($urandom_range(0, 10)) - 5) + int'($urandom_range(0, 6)) - 3;
      end
      queue_beat(m, a, ang, pick_coord(), pick_coord(), pick_coord());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("tb: %0d results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    $display("summary: %0d beats sent, %0d results checked (%0d rotated, %0d passed through,",
             beats_in, results_in, rotations, passthrough);
    $display("summary: %0d error codes), long receiver hold and full drains included, %0d bad",
             error_codes, mismatches);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Driver: keeps a beat on the bus until it is taken, offering beats in bursts with gaps.
  // While the receiver is holding off, gaps are skipped so the block backs up fully.
  always @(negedge clk_i) begin
    rot_beat_t b;
    static int burst_left = 0;
    static int gap_left   = 0;
    if (rst_ni) begin
      if (!s_axis_tvalid_i || beat_taken) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          b = pending_beats.pop_front();
          s_axis_tdata_i  <= {b.z, b.y, b.x, b.angle};
          s_axis_tuser_i  <= {b.axis, b.mode};
          s_axis_tvalid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall rate changes over random spans (never, sometimes, mostly),
  // and once, after enough beats have gone in, it refuses results for a long stretch.
  always @(negedge clk_i) begin
    static int  span_left = 0;
    static int  stall_pct = 0;
    static bit  hold_done = 1'b0;
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && beats_in >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left <= HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (span_left == 0) begin
          span_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        span_left--;
        m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Monitor: at each rising edge, an accepted input beat adds its prediction to the queue,
  // and an accepted output beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    rot_beat_t          b;
    avr_pkg::result_t   got;
    avr_pkg::result_t   want;
    beat_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (beat_taken) begin
        b.angle = s_axis_tdata_i[31:0];
        b.x     = s_axis_tdata_i[63:32];
        b.y     = s_axis_tdata_i[95:64];
        b.z     = s_axis_tdata_i[127:96];
        b.mode  = avr_pkg::mode_e'(s_axis_tuser_i[1:0]);
        b.axis  = avr_pkg::axis_e'(s_axis_tuser_i[3:2]);
        expected_results.push_back(rotate_vector(b));
        beats_in++;
        if (b.mode == avr_pkg::MODE_NONE) passthrough++;
        else if (b.mode == avr_pkg::MODE_BAD || b.axis == avr_pkg::AXIS_BAD) error_codes++;
        else rotations++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.x      = m_axis_tdata_o[31:0];
        got.y      = m_axis_tdata_o[63:32];
        got.z      = m_axis_tdata_o[95:64];
        got.status = avr_pkg::status_e'(m_axis_tuser_o);
        results_in++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: result beat with nothing expected: x=%h y=%h z=%h status=%0d",
                     got.x, got.y, got.z, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("tb: result %0d expected x=%h y=%h z=%h status=%0d",
                       results_in, want.x, want.y, want.z, want.status);
              $display("tb: result %0d got      x=%h y=%h z=%h status=%0d",
                       results_in, got.x, got.y, got.z, got.status);
            end
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timed out after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
